>>> design/plsq_pkg.sv
// Shared types and constants for the positional list store.
// Used by plsq_cell and positional_list_store.
`timescale 1ns / 1ps
`default_nettype none

package plsq_pkg;

	localparam int DEPTH   = 64;
	localparam int DATA_W  = 32;
	localparam int POS_W   = 7;
	localparam int CNT_W   = $clog2(DEPTH + 1);
	localparam int IDX_W   = $clog2(DEPTH);
	localparam int CMP_W   = (POS_W > CNT_W) ? POS_W : CNT_W;
	localparam int OP_W    = 2;
	localparam int STAT_W  = 2;
	localparam int S_DATA_W = ((POS_W + 2 * DATA_W + 7) / 8) * 8;
	localparam int M_DATA_W = ((CNT_W + DATA_W + 7) / 8) * 8;

	typedef enum logic [OP_W-1:0] {
		OP_INSERT  = 2'd0,
		OP_DELETE  = 2'd1,
		OP_REPLACE = 2'd2,
		OP_READ    = 2'd3
	} op_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2,
		ST_RANGE = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		CELL_HOLD,
		CELL_LOAD,
		CELL_FROM_LEFT,
		CELL_FROM_RIGHT,
		CELL_REPLACE
	} cell_op_t;

	typedef struct packed {
		cell_op_t op;
		logic     rd_sel;
	} cell_ctrl_t;

	typedef struct packed {
		logic [DATA_W-1:0] value;
		logic [DATA_W-1:0] new_value;
	} cell_bus_t;

endpackage

`default_nettype wire

>>> design/plsq_cell.sv
// One slot of the list: holds a value, loads, shifts from a neighbor or replaces on match.
// Depends on plsq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module plsq_cell import plsq_pkg::*; (
	input  wire logic              clk,
	input  wire cell_ctrl_t        ctrl,
	input  wire cell_bus_t         bus,
	input  wire logic [DATA_W-1:0] left_data,
	input  wire logic [DATA_W-1:0] right_data,
	output logic      [DATA_W-1:0] slot,
	output logic      [DATA_W-1:0] rd_data
);

	logic [DATA_W-1:0] slot_q;

	always_ff @(posedge clk) begin
		unique case (ctrl.op)
			CELL_LOAD:       slot_q <= bus.value;
			CELL_FROM_LEFT:  slot_q <= left_data;
			CELL_FROM_RIGHT: slot_q <= right_data;
			CELL_REPLACE: begin
				if (slot_q == bus.value) begin
					slot_q <= bus.new_value;
				end
			end
			default:         slot_q <= slot_q;
		endcase
	end

	assign slot    = slot_q;
	assign rd_data = ctrl.rd_sel ? slot_q : '0;

endmodule

`default_nettype wire

>>> design/positional_list_store.sv
// Top level of the positional list store: command decode, row of slot cells, result register.
// Depends on plsq_pkg and plsq_cell.
`timescale 1ns / 1ps
`default_nettype none

// Ordered list of up to DEPTH signed 32-bit values, one command per item. Every command
// finishes in the cycle it is accepted: the whole row of cells shifts, loads or replaces in
// parallel, and the result appears on the master side in the next cycle. A new item can be
// accepted every cycle while the result register is free or being drained. Slots hold no
// reset value and need no clearing pass; only slots below the count are ever read.
module positional_list_store import plsq_pkg::*; (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                s_tvalid,
	output logic                     s_tready,
	input  wire logic [S_DATA_W-1:0] s_tdata,  // position[6:0], value[38:7], new_value[70:39]
	input  wire logic [OP_W-1:0]     s_tuser,  // op[1:0]
	output logic                     m_tvalid,
	input  wire logic                m_tready,
	output logic      [M_DATA_W-1:0] m_tdata,  // count[6:0], read_value[38:7]
	output logic      [STAT_W-1:0]   m_tuser   // status[1:0]
);

	logic [CNT_W-1:0]    count_q;
	logic                m_tvalid_q;
	logic [M_DATA_W-1:0] m_tdata_q;
	logic [STAT_W-1:0]   m_tuser_q;

	logic              s_acc;
	op_t               op;
	logic [POS_W-1:0]  pos;
	logic [CMP_W-1:0]  pos_x, cnt_x;
	status_t           stat;
	logic              ins_do, del_do, rd_do;
	logic [CMP_W-1:0]  idx_x;
	logic [CNT_W-1:0]  count_nxt;
	logic [DATA_W-1:0] rd_value;
	cell_bus_t         bus;

	logic [DATA_W-1:0] slots   [DEPTH];
	logic [DATA_W-1:0] rd_part [DEPTH];
	cell_ctrl_t        ctrl    [DEPTH];

	assign s_tready = !m_tvalid_q || m_tready;
	assign s_acc    = s_tvalid && s_tready;
	assign op       = op_t'(s_tuser);
	assign pos      = s_tdata[POS_W-1:0];
	assign pos_x    = CMP_W'(pos);
	assign cnt_x    = CMP_W'(count_q);
	assign bus.value     = s_tdata[POS_W +: DATA_W];
	assign bus.new_value = s_tdata[POS_W+DATA_W +: DATA_W];

	// command decode: status, target slot, next count
	always_comb begin
		stat      = ST_OK;
		ins_do    = 1'b0;
		del_do    = 1'b0;
		rd_do     = 1'b0;
		idx_x     = '0;
		count_nxt = count_q;
		unique case (op)
			OP_INSERT: begin
				if (count_q >= CNT_W'(DEPTH)) begin
					stat = ST_FULL;
				end else if (pos == '0) begin
					ins_do = 1'b1;
					idx_x  = cnt_x;
				end else if (pos_x <= cnt_x || (pos_x == CMP_W'(1) && count_q == '0)) begin
					ins_do = 1'b1;
					idx_x  = pos_x - CMP_W'(1);
				end else begin
					stat = ST_RANGE;
				end
				if (ins_do) begin
					count_nxt = count_q + CNT_W'(1);
				end
			end
			OP_DELETE, OP_READ: begin
				if (count_q == '0) begin
					stat = ST_EMPTY;
				end else if (pos == '0) begin
					idx_x = cnt_x - CMP_W'(1);
				end else if (pos_x <= cnt_x) begin
					idx_x = pos_x - CMP_W'(1);
				end else begin
					stat = ST_RANGE;
				end
				if (stat == ST_OK) begin
					if (op == OP_DELETE) begin
						del_do    = 1'b1;
						count_nxt = count_q - CNT_W'(1);
					end else begin
						rd_do = 1'b1;
					end
				end
			end
			default: ;
		endcase
	end

	// per-cell control from its index against the target slot and the count
	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			ctrl[i].op     = CELL_HOLD;
			ctrl[i].rd_sel = rd_do && (idx_x == CMP_W'(i));
			if (s_acc) begin
				if (ins_do && CMP_W'(i) == idx_x) begin
					ctrl[i].op = CELL_LOAD;
				end else if (ins_do && CMP_W'(i) > idx_x && CMP_W'(i) <= cnt_x) begin
					ctrl[i].op = CELL_FROM_LEFT;
				end else if (del_do && CMP_W'(i) >= idx_x
					&& CMP_W'(i) + CMP_W'(1) < cnt_x) begin
					ctrl[i].op = CELL_FROM_RIGHT;
				end else if (op == OP_REPLACE && CMP_W'(i) < cnt_x) begin
					ctrl[i].op = CELL_REPLACE;
				end
			end
		end
	end

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [DATA_W-1:0] left_d, right_d;
		if (i == 0) begin : g_first
			assign left_d = '0;
		end else begin : g_left
			assign left_d = slots[i-1];
		end
		if (i == DEPTH - 1) begin : g_last
			assign right_d = '0;
		end else begin : g_right
			assign right_d = slots[i+1];
		end
		plsq_cell u_cell (
			.clk        (clk),
			.ctrl       (ctrl[i]),
			.bus        (bus),
			.left_data  (left_d),
			.right_data (right_d),
			.slot       (slots[i]),
			.rd_data    (rd_part[i])
		);
	end

	// at most one cell is selected, so an OR gathers the read value
	always_comb begin
		rd_value = '0;
		for (int i = 0; i < DEPTH; i++) begin
			rd_value = rd_value | rd_part[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (s_acc) begin
				count_q    <= count_nxt;
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_acc) begin
			m_tdata_q <= M_DATA_W'({rd_value, count_nxt});
			m_tuser_q <= stat;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("count above depth");

	a_ins_grows: assert property (@(posedge clk) disable iff (!arst_n)
		s_acc && op == OP_INSERT && stat == ST_OK |=> count_q == $past(count_q) + CNT_W'(1))
		else $error("insert did not grow the list");

	a_full_only_at_depth: assert property (@(posedge clk) disable iff (!arst_n)
		s_acc && stat == ST_FULL |-> count_q == CNT_W'(DEPTH))
		else $error("full reported below depth");

	a_one_read_sel: assert property (@(posedge clk) disable iff (!arst_n)
		s_acc |-> $onehot0({ins_do, del_do, rd_do}))
		else $error("more than one list action decoded");

endmodule

`default_nettype wire
